[hdl/psbd_pkg.sv]
package psbd_pkg;

    // command codes of an input word
    localparam logic [2:0] CMD_WRITE   = 3'd0;
    localparam logic [2:0] CMD_DRAW    = 3'd1;
    localparam logic [2:0] CMD_BACKUP  = 3'd2;
    localparam logic [2:0] CMD_RESTORE = 3'd3;
    localparam logic [2:0] CMD_CLEAR   = 3'd4;

    // configuration register indexes
    localparam logic [2:0] REG_CLIP_LEFT    = 3'd0;
    localparam logic [2:0] REG_CLIP_TOP     = 3'd1;
    localparam logic [2:0] REG_CLIP_RIGHT   = 3'd2;
    localparam logic [2:0] REG_CLIP_BOTTOM  = 3'd3;
    localparam logic [2:0] REG_ORIGIN_X     = 3'd4;
    localparam logic [2:0] REG_ORIGIN_Y     = 3'd5;
    localparam logic [2:0] REG_SPRITE_WIDTH = 3'd6;
    localparam logic [2:0] REG_DAY_LEVEL    = 3'd7;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 12;

    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  palette_index;
        logic [15:0] palette_color;
        logic        last_pixel;
    } in_word_t;

    typedef struct packed {
        logic [16:0] frame_address;
        logic [15:0] pixel_color;
    } out_word_t;

    // controller to datapath
    typedef struct packed {
        logic take_write;  // palette entry write at this edge
        logic take_draw;   // draw word accepted: issue palette read, step position
        logic take_walk;   // backup, restore or clear accepted
        logic walk_read;   // read one entry of the walk
        logic fetch;       // palette data valid: check and multiply
        logic load_out;    // load the output register
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic walk_last;   // walk counter on the last active entry
        logic shown;       // fetched pixel gives a framebuffer write
        logic out_free;    // output register can take a word
    } dp_status_t;

endpackage

[hdl/psbd_ctrl.sv]
module psbd_ctrl import psbd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_command,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_WALK  = 5'b00010,
        ST_DRAIN = 5'b00100,
        ST_FETCH = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   take;

    assign s_ready = (state_reg == ST_IDLE);
    assign take    = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (take) begin
                    case (s_command)
                        CMD_WRITE: begin
                            cmd.take_write = 1'b1;
                        end
                        CMD_DRAW: begin
                            cmd.take_draw = 1'b1;
                            state_next    = ST_FETCH;
                        end
                        CMD_BACKUP, CMD_RESTORE, CMD_CLEAR: begin
                            cmd.take_walk = 1'b1;
                            state_next    = ST_WALK;
                        end
                        default: begin
                            // unknown command: dropped
                        end
                    endcase
                end
            end
            ST_WALK: begin
                cmd.walk_read = 1'b1;
                if (status.walk_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_IDLE;
            end
            ST_FETCH: begin
                cmd.fetch  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!status.shown) begin
                    state_next = ST_IDLE;
                end else if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[hdl/psbd_dp.sv]
module psbd_dp import psbd_pkg::*; #(
    parameter int SCREEN_COLUMNS  = 320,
    parameter int SCREEN_ROWS     = 240,
    parameter int PALETTE_ENTRIES = 256,
    parameter int TRANSPARENT_KEY = 63519,
    parameter int RG_DIM_Q8       = 215,
    parameter int B_DIM_Q8        = 143
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  in_word_t               s_data,
    input  ctrl_cmd_t              cmd,
    output dp_status_t             status,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_word_t              m_data
);

    localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam logic [8:0]       ENTRIES_K = 9'(PALETTE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(PALETTE_ENTRIES - 1);
    localparam logic [15:0]      KEY_K     = 16'(TRANSPARENT_KEY);
    localparam logic [8:0]       RG_K      = 9'(RG_DIM_Q8);
    localparam logic [8:0]       B_K       = 9'(B_DIM_Q8);
    localparam logic [10:0]      COLS_K    = 11'(SCREEN_COLUMNS);
    localparam logic signed [13:0] SCR_COLS_S = 14'(SCREEN_COLUMNS);
    localparam logic signed [13:0] SCR_ROWS_S = 14'(SCREEN_ROWS);

    // configuration registers
    logic [11:0] clip_left_reg, clip_top_reg, clip_right_reg, clip_bottom_reg;
    logic [11:0] origin_x_reg, origin_y_reg;
    logic [10:0] sprite_width_reg;
    logic [8:0]  day_level_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clip_left_reg    <= 12'd0;
            clip_top_reg     <= 12'd0;
            clip_right_reg   <= 12'd320;
            clip_bottom_reg  <= 12'd240;
            origin_x_reg     <= 12'd0;
            origin_y_reg     <= 12'd0;
            sprite_width_reg <= 11'd16;
            day_level_reg    <= 9'd256;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_CLIP_LEFT:    clip_left_reg    <= cfg_wdata;
                REG_CLIP_TOP:     clip_top_reg     <= cfg_wdata;
                REG_CLIP_RIGHT:   clip_right_reg   <= cfg_wdata;
                REG_CLIP_BOTTOM:  clip_bottom_reg  <= cfg_wdata;
                REG_ORIGIN_X:     origin_x_reg     <= cfg_wdata;
                REG_ORIGIN_Y:     origin_y_reg     <= cfg_wdata;
                REG_SPRITE_WIDTH: sprite_width_reg <= cfg_wdata[10:0];
                REG_DAY_LEVEL:    day_level_reg    <= cfg_wdata[8:0];
                default: begin
                end
            endcase
        end
    end

    // dim factors, registered from the day level
    logic [8:0]  level, diff;
    logic [17:0] rg_full, bl_full;
    logic [16:0] rg_reg, bl_reg;

    assign level   = (day_level_reg > 9'd256) ? 9'd256 : day_level_reg;
    assign diff    = 9'd256 - level;
    assign rg_full = 18'h10000 - 18'(RG_K) * 18'(diff);
    assign bl_full = 18'h10000 - 18'(B_K) * 18'(diff);

    always_ff @(posedge aclk) begin
        rg_reg <= rg_full[16:0];
        bl_reg <= bl_full[16:0];
    end

    // sprite position
    logic [9:0]  col_reg, col_next;
    logic [11:0] row_reg, row_next;
    logic [10:0] width_eff, col_inc;
    logic signed [13:0] x_pos, y_pos, cl_s, cr_s, ct_s, cb_s;
    logic in_win, idx_ok_in;

    assign width_eff = (sprite_width_reg == 11'd0)    ? 11'd1 :
                       (sprite_width_reg > 11'd1024) ? 11'd1024 : sprite_width_reg;
    assign col_inc   = {1'b0, col_reg} + 11'd1;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (s_data.last_pixel) begin
            col_next = '0;
            row_next = '0;
        end else if (col_inc >= width_eff) begin
            col_next = '0;
            row_next = row_reg + 12'd1;
        end else begin
            col_next = col_inc[9:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (cmd.take_draw) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign x_pos = $signed({{2{origin_x_reg[11]}}, origin_x_reg}) + $signed({4'b0, col_reg});
    assign y_pos = $signed({{2{origin_y_reg[11]}}, origin_y_reg}) + $signed({2'b0, row_reg});
    assign cl_s  = $signed({{2{clip_left_reg[11]}}, clip_left_reg});
    assign cr_s  = $signed({{2{clip_right_reg[11]}}, clip_right_reg});
    assign ct_s  = $signed({{2{clip_top_reg[11]}}, clip_top_reg});
    assign cb_s  = $signed({{2{clip_bottom_reg[11]}}, clip_bottom_reg});

    assign in_win = (x_pos >= cl_s) && (x_pos < cr_s) &&
                    (x_pos >= 14'sd0) && (x_pos < SCR_COLS_S) &&
                    (y_pos >= ct_s) && (y_pos < cb_s) &&
                    (y_pos >= 14'sd0) && (y_pos < SCR_ROWS_S);
    assign idx_ok_in = ({1'b0, s_data.palette_index} < ENTRIES_K);

    // stage a: captured with the draw word
    logic       win_reg, idx_ok_reg;
    logic [9:0] xa_reg, ya_reg;

    always_ff @(posedge aclk) begin
        if (cmd.take_draw) begin
            win_reg    <= in_win;
            idx_ok_reg <= idx_ok_in;
            xa_reg     <= x_pos[9:0];
            ya_reg     <= y_pos[9:0];
        end
    end

    // walk counter and pending write of the walk
    logic [IDX_W-1:0] walk_idx_reg, pend_addr_reg;
    logic             pend_reg;
    logic [2:0]       op_reg;
    logic [15:0]      clr_color_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            walk_idx_reg <= '0;
            pend_reg     <= 1'b0;
        end else begin
            pend_reg <= cmd.walk_read;
            if (cmd.take_walk) begin
                walk_idx_reg <= '0;
            end else if (cmd.walk_read) begin
                walk_idx_reg <= (walk_idx_reg == LAST_IDX) ? '0 : walk_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pend_addr_reg <= walk_idx_reg;
        if (cmd.take_walk) begin
            op_reg        <= s_data.command;
            clr_color_reg <= s_data.palette_color;
        end
    end

    // palette and backup memories
    logic [15:0]      pal_mem [PALETTE_ENTRIES];
    logic [15:0]      bk_mem  [PALETTE_ENTRIES];
    logic [15:0]      pal_rd_reg, bk_rd_reg;
    logic [IDX_W-1:0] pal_raddr;

    assign pal_raddr = cmd.take_draw ? s_data.palette_index[IDX_W-1:0] : walk_idx_reg;

    always_ff @(posedge aclk) begin
        pal_rd_reg <= pal_mem[pal_raddr];
        if (cmd.take_write && idx_ok_in) begin
            pal_mem[s_data.palette_index[IDX_W-1:0]] <= s_data.palette_color;
        end else if (pend_reg && op_reg == CMD_RESTORE) begin
            pal_mem[pend_addr_reg] <= bk_rd_reg;
        end else if (pend_reg && op_reg == CMD_CLEAR && pal_rd_reg != KEY_K) begin
            pal_mem[pend_addr_reg] <= clr_color_reg;
        end
    end

    always_ff @(posedge aclk) begin
        bk_rd_reg <= bk_mem[walk_idx_reg];
        if (pend_reg && op_reg == CMD_BACKUP) begin
            bk_mem[pend_addr_reg] <= pal_rd_reg;
        end
    end

    // stage b: transparency check, dim products and address
    logic        shown_reg;
    logic [21:0] r_prod_reg, b_prod_reg;
    logic [22:0] g_prod_reg;
    logic [20:0] addr_full;
    logic [16:0] addr_reg;

    assign addr_full = 21'(ya_reg) * 21'(COLS_K) + 21'(xa_reg);

    always_ff @(posedge aclk) begin
        if (cmd.fetch) begin
            shown_reg  <= idx_ok_reg && win_reg && (pal_rd_reg != KEY_K);
            r_prod_reg <= 22'(pal_rd_reg[15:11]) * 22'(rg_reg);
            g_prod_reg <= 23'(pal_rd_reg[10:5]) * 23'(rg_reg);
            b_prod_reg <= 22'(pal_rd_reg[4:0]) * 22'(bl_reg);
            addr_reg   <= addr_full[16:0];
        end
    end

    // output register
    logic      m_valid_reg;
    out_word_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_data_reg.frame_address <= addr_reg;
            m_data_reg.pixel_color   <= {r_prod_reg[20:16], g_prod_reg[21:16],
                                         b_prod_reg[20:16]};
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign status.walk_last = (walk_idx_reg == LAST_IDX);
    assign status.shown     = shown_reg;
    assign status.out_free  = !m_valid_reg || m_ready;

endmodule

[hdl/palette_sprite_blit_dimmer.sv]
// draw word: from acceptance to the framebuffer word in the output register through the
// palette read, multiply stage and output load; the next word is taken only after these,
// later while an earlier framebuffer word still waits in the output register
// palette write and unknown command: the controller stays idle, an unknown command is dropped
// backup, restore, clear: one entry per cycle over the memory port
// reset (aresetn, synchronous, active low): idle, counters zero, config at defaults;
// palette and backup memories hold nothing defined until written
module palette_sprite_blit_dimmer import psbd_pkg::*; #(
    parameter int SCREEN_COLUMNS  = 320,
    parameter int SCREEN_ROWS     = 240,
    parameter int PALETTE_ENTRIES = 256,
    parameter int TRANSPARENT_KEY = 63519,
    parameter int RG_DIM_Q8       = 215,
    parameter int B_DIM_Q8        = 143
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration write port
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    // command words in
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_word_t               s_data,
    // framebuffer write words out
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_word_t              m_data
);

    // commands from the controller, status back from the datapath
    ctrl_cmd_t  cmd;
    dp_status_t status;

    // controller: takes a word only when idle, sequences walks and the
    // draw pipeline, and holds a drawn pixel until the output register is free
    psbd_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_data.command),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath: configuration registers, sprite position counters,
    // palette and backup memories, dim multipliers and the output register
    // (the output register lets a new word in while a result waits)
    psbd_dp #(
        .SCREEN_COLUMNS  (SCREEN_COLUMNS),
        .SCREEN_ROWS     (SCREEN_ROWS),
        .PALETTE_ENTRIES (PALETTE_ENTRIES),
        .TRANSPARENT_KEY (TRANSPARENT_KEY),
        .RG_DIM_Q8       (RG_DIM_Q8),
        .B_DIM_Q8        (B_DIM_Q8)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .cmd       (cmd),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
